### sv/thruster_mix_reverse_lockout_assert.svh
// Assertion macros for the thruster mixer checker.
// Self-contained; included by files that carry concurrent assertions.
`ifndef THRUSTER_MIX_REVERSE_LOCKOUT_ASSERT_SVH
`define THRUSTER_MIX_REVERSE_LOCKOUT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define TMRL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("thruster mixer assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define TMRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("thruster mixer assertion failed");

`endif

### sv/tmrl_pkg.sv
// Shared types and constants of the thruster mixer with reverse lockout.
// No dependencies; used by the interfaces, the mixer, the top level and the checker.
package tmrl_pkg;

	localparam int CMD_W      = 9;   // width of one signed thrust command
	localparam int MIX_W      = 11;  // width of a mixed value before range check
	localparam int MODE_W     = 2;
	localparam int MAG_W      = 8;
	localparam int IDX_W      = 3;   // engine index field
	localparam int ECNT_W     = 4;   // engine_count register
	localparam int LOCK_W     = 16;  // reverse_lockout_ticks register
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int MIX_SLOTS  = 3;   // engines fed by the mixer
	localparam int MIX_LIMIT  = 255;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENGINE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_VERT  = 2'd2;

	// Command kinds
	localparam logic CMD_SPEED = 1'b0;
	localparam logic CMD_DIR   = 1'b1;

	typedef enum logic [MODE_W-1:0] {
		MODE_STOP  = 2'd0,
		MODE_MOVE  = 2'd1,
		MODE_YAW   = 2'd2,
		MODE_PITCH = 2'd3
	} mode_t;

	typedef struct packed {
		logic signed [CMD_W-1:0] vert_manual;
		logic signed [CMD_W-1:0] vert_auto;
		logic signed [CMD_W-1:0] move_speed;
		logic signed [CMD_W-1:0] rotate_speed;
		mode_t                   mode;
	} tick_t;

	// Mixer result for engines 0..2
	typedef struct packed {
		logic                             stop;
		logic [MIX_SLOTS-1:0]             upd;
		logic [MIX_SLOTS-1:0][MAG_W-1:0]  mag;
		logic [MIX_SLOTS-1:0]             dir;
	} mix_t;

endpackage

### sv/tmrl_if.sv
// Handshake channels of the thruster mixer: tick input, command output, config writes.
// Depends on tmrl_pkg for field widths.
interface tmrl_tick_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [tmrl_pkg::CMD_W-1:0]    vert_manual;
	logic signed [tmrl_pkg::CMD_W-1:0]    vert_auto;
	logic signed [tmrl_pkg::CMD_W-1:0]    move_speed;
	logic signed [tmrl_pkg::CMD_W-1:0]    rotate_speed;
	logic [tmrl_pkg::MODE_W-1:0]          mode;

	modport source (output valid, vert_manual, vert_auto, move_speed, rotate_speed, mode,
		input ready);
	modport sink (input valid, vert_manual, vert_auto, move_speed, rotate_speed, mode,
		output ready);
endinterface

interface tmrl_cmd_if;
	logic                          valid;
	logic                          ready;
	logic                          cmd_kind;
	logic [tmrl_pkg::IDX_W-1:0]    engine_index;
	logic [tmrl_pkg::MAG_W-1:0]    cmd_value;

	modport source (output valid, cmd_kind, engine_index, cmd_value, input ready);
	modport sink (input valid, cmd_kind, engine_index, cmd_value, output ready);
endinterface

interface tmrl_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [tmrl_pkg::CFG_IDX_W-1:0]    index;
	logic [tmrl_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/tmrl_mix.sv
// Thrust mixer: turns one tick's commands into targets for engines 0..2.
// Depends on tmrl_pkg (tick_t, mix_t, mode codes).
module tmrl_mix (
	input  tmrl_pkg::tick_t item,
	input  logic            manual_vertical,
	output tmrl_pkg::mix_t  mix
);
	import tmrl_pkg::*;

	logic signed [MIX_W-1:0] val [MIX_SLOTS];
	logic                    drive1;  // engines 1 and 2 take a new mix
	logic signed [MIX_W-1:0] mv;
	logic signed [MIX_W-1:0] rt;

	assign mv = MIX_W'(item.move_speed);
	assign rt = MIX_W'(item.rotate_speed);

	// Mix per mode
	always_comb begin
		val[0] = manual_vertical ? MIX_W'(item.vert_manual) : MIX_W'(item.vert_auto);
		val[1] = '0;
		val[2] = '0;
		drive1 = 1'b1;
		case (item.mode) inside
			MODE_STOP: begin
				drive1 = 1'b0;
			end
			MODE_YAW: begin
				val[1] = rt;
				val[2] = -rt;
			end
			MODE_MOVE, MODE_PITCH: begin
				if (rt >= 0) begin
					val[1] = mv - rt;
					val[2] = mv;
				end else begin
					val[1] = mv;
					val[2] = mv + rt;
				end
			end
			default: begin
				drive1 = 1'b0;
			end
		endcase
	end

	// Range check and fold into magnitude and direction
	always_comb begin
		mix.stop = (item.mode == MODE_STOP);
		for (int i = 0; i < MIX_SLOTS; i++) begin
			mix.upd[i] = (val[i] >= -MIX_LIMIT) && (val[i] <= MIX_LIMIT) && (i == 0 || drive1);
			mix.dir[i] = val[i] < 0;
			mix.mag[i] = (val[i] < 0) ? MAG_W'(-val[i]) : MAG_W'(val[i]);
		end
	end

endmodule

### sv/thruster_mix_reverse_lockout.sv
// Thruster mixer with reverse lockout. Takes one tick per clock cycle while not stalled;
// an accepted tick waits in the input register, and its result is loaded into the
// command register when it is processed. One more tick is thus taken while a command
// waits to be transferred; the input stalls only when both registers are full.
// Each tick yields zero or one command (speed or direction) for the round-robin engine.
// Configuration writes are always taken and apply to the next processed tick.
module thruster_mix_reverse_lockout #(
	parameter int MAX_ENGINES = 8,
	parameter int AGE_BITS    = 16
) (
	input logic        clk,
	input logic        arst_n,
	tmrl_cfg_if.sink   cfg,
	tmrl_tick_if.sink  tick,
	tmrl_cmd_if.source cmd
);
	import tmrl_pkg::*;

	localparam int PTR_W = $clog2(MAX_ENGINES);
	localparam int NW    = $clog2(MAX_ENGINES + 1);
	localparam int CMP_W = (AGE_BITS > LOCK_W) ? AGE_BITS : LOCK_W;

	// Configuration
	logic [ECNT_W-1:0] ecount_q;
	logic [LOCK_W-1:0] lockout_q;
	logic              manual_q;

	// Input register
	logic  s1_v;
	tick_t tick_s1;

	// Per-engine state
	logic [MAG_W-1:0]    tmag_q [MAX_ENGINES];
	logic [MAG_W-1:0]    smag_q [MAX_ENGINES];
	logic                tdir_q [MAX_ENGINES];
	logic                sdir_q [MAX_ENGINES];
	logic [AGE_BITS-1:0] age_q  [MAX_ENGINES];
	logic [PTR_W-1:0]    ptr_q;

	logic [MAG_W-1:0]    tmag_n [MAX_ENGINES];
	logic [MAG_W-1:0]    smag_n [MAX_ENGINES];
	logic                tdir_n [MAX_ENGINES];
	logic                sdir_n [MAX_ENGINES];
	logic [AGE_BITS-1:0] age_n  [MAX_ENGINES];

	// Command register
	logic             out_v_q;
	logic             kind_q;
	logic [IDX_W-1:0] idx_q;
	logic [MAG_W-1:0] val_q;

	mix_t           mix;
	logic [NW-1:0]  n_use;
	logic [PTR_W:0] ptr_inc;
	logic [PTR_W-1:0] p;
	logic           dir_go;
	logic           mag_go;
	logic           process;
	logic           tick_acc;

	assign cfg.ready  = 1'b1;
	assign process    = s1_v && (!out_v_q || cmd.ready);
	assign tick.ready = !s1_v || process;
	assign tick_acc   = tick.valid && tick.ready;

	assign cmd.valid        = out_v_q;
	assign cmd.cmd_kind     = kind_q;
	assign cmd.engine_index = idx_q;
	assign cmd.cmd_value    = val_q;

	tmrl_mix u_mix (
		.item            (tick_s1),
		.manual_vertical (manual_q),
		.mix             (mix)
	);

	// Engines in use: zero counts as one, clamp at the array depth
	always_comb begin
		if (ecount_q == '0) begin
			n_use = NW'(1);
		end else if (32'(ecount_q) > 32'(MAX_ENGINES)) begin
			n_use = NW'(MAX_ENGINES);
		end else begin
			n_use = NW'(ecount_q);
		end
	end

	// Advance the round-robin pointer, wrap at the engine count
	always_comb begin
		ptr_inc = {1'b0, ptr_q} + 1'b1;
		p = (32'(ptr_inc) >= 32'(n_use)) ? '0 : ptr_inc[PTR_W-1:0];
	end

	// Next targets, ages and sent state for this tick
	always_comb begin
		for (int i = 0; i < MAX_ENGINES; i++) begin
			tmag_n[i] = tmag_q[i];
			tdir_n[i] = tdir_q[i];
			smag_n[i] = smag_q[i];
			sdir_n[i] = sdir_q[i];
			age_n[i]  = age_q[i];
			if (NW'(i) < n_use) begin
				if (mix.stop) begin
					tmag_n[i] = '0;
					tdir_n[i] = 1'b0;
				end else if (i < MIX_SLOTS) begin
					if (mix.upd[i[1:0]]) begin
						tmag_n[i] = mix.mag[i[1:0]];
						tdir_n[i] = mix.dir[i[1:0]];
					end
				end
				if (age_q[i] != '1) begin
					age_n[i] = age_q[i] + 1'b1;
				end
			end
		end

		dir_go = (CMP_W'(age_n[p]) >= CMP_W'(lockout_q)) && (tdir_n[p] != sdir_q[p]);
		mag_go = tmag_n[p] != smag_q[p];

		if (dir_go) begin
			age_n[p]  = '0;
			sdir_n[p] = tdir_n[p];
		end else if (mag_go) begin
			smag_n[p] = tmag_n[p];
		end
	end

	// Configuration writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecount_q  <= ECNT_W'(3);
			lockout_q <= LOCK_W'(20);
			manual_q  <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_ENGINE_COUNT: ecount_q  <= cfg.data[ECNT_W-1:0];
				CFG_LOCKOUT:      lockout_q <= cfg.data[LOCK_W-1:0];
				CFG_MANUAL_VERT:  manual_q  <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	// Input register: hold a tick until it is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (tick_acc) begin
			s1_v <= 1'b1;
		end else if (process) begin
			s1_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			tick_s1 <= '{
				vert_manual:  tick.vert_manual,
				vert_auto:    tick.vert_auto,
				move_speed:   tick.move_speed,
				rotate_speed: tick.rotate_speed,
				mode:         mode_t'(tick.mode)
			};
		end
	end

	// Engine state update on each processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ENGINES; i++) begin
				tmag_q[i] <= '0;
				smag_q[i] <= '0;
				tdir_q[i] <= 1'b0;
				sdir_q[i] <= 1'b0;
				age_q[i]  <= '0;
			end
			ptr_q <= '0;
		end else if (process) begin
			for (int i = 0; i < MAX_ENGINES; i++) begin
				tmag_q[i] <= tmag_n[i];
				smag_q[i] <= smag_n[i];
				tdir_q[i] <= tdir_n[i];
				sdir_q[i] <= sdir_n[i];
				age_q[i]  <= age_n[i];
			end
			ptr_q <= p;
		end
	end

	// Command register: load on process, drop after transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (process) begin
			out_v_q <= dir_go || mag_go;
		end else if (cmd.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			kind_q <= dir_go ? CMD_DIR : CMD_SPEED;
			idx_q  <= IDX_W'(p);
			val_q  <= dir_go ? MAG_W'(tdir_n[p]) : tmag_n[p];
		end
	end

endmodule

### sv/tmrl_checker.sv
// Port-level checks for the thruster mixer, bound to the top level.
// Depends on tmrl_pkg and thruster_mix_reverse_lockout_assert.svh.
`include "thruster_mix_reverse_lockout_assert.svh"

module tmrl_checker #(
	parameter int MAX_ENGINES = 8
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       tick_ready,
	input logic                       cmd_valid,
	input logic                       cmd_ready,
	input logic                       cmd_kind,
	input logic [tmrl_pkg::IDX_W-1:0] engine_index,
	input logic [tmrl_pkg::MAG_W-1:0] cmd_value
);
	import tmrl_pkg::*;

	logic                   stalled;
	logic [IDX_W+MAG_W:0]   cmd_word;
	assign stalled  = cmd_valid && !cmd_ready;
	assign cmd_word = {cmd_kind, engine_index, cmd_value};

	// A waiting command holds until transferred
	`TMRL_ASSERT_NEXT(a_cmd_hold, clk, arst_n, stalled, cmd_valid && $stable(cmd_word))

	// The tick input backs up only behind a stalled command
	`TMRL_ASSERT_IMPLY(a_tick_backpressure, clk, arst_n, !tick_ready, stalled)

	// A direction command carries a single bit
	`TMRL_ASSERT_IMPLY(a_dir_value, clk, arst_n, cmd_valid && cmd_kind == CMD_DIR, cmd_value <= 8'd1)

	// Commands address only engines that exist
	`TMRL_ASSERT_IMPLY(a_engine_range, clk, arst_n, cmd_valid, 32'(engine_index) < 32'(MAX_ENGINES))

endmodule

bind thruster_mix_reverse_lockout tmrl_checker #(
	.MAX_ENGINES (MAX_ENGINES)
) u_tmrl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_ready   (tick.ready),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.cmd_kind     (cmd.cmd_kind),
	.engine_index (cmd.engine_index),
	.cmd_value    (cmd.cmd_value)
);

### dv/thruster_mix_reverse_lockout_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the thruster mixer with reverse lockout: feeds ticks,
// writes the three registers between phases and checks every command against a mirror.
// Depends on tmrl_pkg, the channel interfaces in tmrl_if.sv and the mixer RTL.
module thruster_mix_reverse_lockout_test;
	import tmrl_pkg::*;

	localparam int          ENGINES_MAX   = 8;
	localparam logic [15:0] AGE_TOP       = 16'hFFFF;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          HOLD_CYCLES   = 64;

	typedef struct packed {
		logic             kind;
		logic [IDX_W-1:0] engine;
		logic [MAG_W-1:0] value;
	} engine_cmd_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	tmrl_tick_if tick_ch();
	tmrl_cmd_if  cmd_ch();
	tmrl_cfg_if  cfg_ch();

	thruster_mix_reverse_lockout u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.tick   (tick_ch),
		.cmd    (cmd_ch)
	);

	// Mirror of the mixer state and its registers
	logic [MAG_W-1:0]  aim_mag  [ENGINES_MAX] = '{default: '0};
	logic [MAG_W-1:0]  sent_mag [ENGINES_MAX] = '{default: '0};
	logic              aim_rev  [ENGINES_MAX] = '{default: 1'b0};
	logic              sent_rev [ENGINES_MAX] = '{default: 1'b0};
	logic [15:0]       rev_age  [ENGINES_MAX] = '{default: '0};
	int unsigned       rr_ptr                 = 0;
	logic [ECNT_W-1:0] reg_engines            = 4'd3;
	logic [LOCK_W-1:0] reg_lockout            = 16'd20;
	logic              reg_manual             = 1'b0;

	tick_t       tick_backlog [$];
	engine_cmd_t cmd_due      [$];
	tick_t       next_tick;
	tick_t       seen_tick;
	engine_cmd_t seen_cmd;
	engine_cmd_t due_cmd;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left     = 0;
	logic hold_go     = 1'b0;
	int ticks_queued  = 0;
	int ticks_taken   = 0;
	int cmds_seen     = 0;
	int dir_cmds      = 0;
	int settings_run  = 1;
	int err_count     = 0;

	always #2 clk = ~clk;

	// Print one line per mismatch and count it
	task automatic report_mismatch(string msg);
		err_count++;
		$display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	function automatic int engines_active();
		if (reg_engines == 0)
			return 1;
		if (reg_engines > ENGINES_MAX)
			return ENGINES_MAX;
		return int'(reg_engines);
	endfunction

	// Set one engine's target; out of range mixes and absent engines leave it alone
	function automatic void aim_engine(int v, int e, int n);
		if (e >= n)
			return;
		if (v >= -MIX_LIMIT && v < 0) begin
			aim_mag[e] = MAG_W'(-v);
			aim_rev[e] = 1'b1;
		end else if (v >= 0 && v <= MIX_LIMIT) begin
			aim_mag[e] = MAG_W'(v);
			aim_rev[e] = 1'b0;
		end
	endfunction

	// Mix one tick, age the engines, advance the pointer and pick the command due
	function automatic bit mix_tick(tick_t t, output engine_cmd_t c);
		int n;
		int vm;
		int va;
		int mv;
		int rt;
		int p;
		n  = engines_active();
		vm = t.vert_manual;
		va = t.vert_auto;
		mv = t.move_speed;
		rt = t.rotate_speed;
		c  = '0;
		aim_engine(reg_manual ? vm : va, 0, n);
		case (t.mode)
			MODE_STOP: begin
				for (int i = 0; i < n; i++)
					aim_engine(0, i, n);
			end
			MODE_YAW: begin
				aim_engine(rt, 1, n);
				aim_engine(-rt, 2, n);
			end
			default: begin
				if (rt >= 0) begin
					aim_engine(mv - rt, 1, n);
					aim_engine(mv, 2, n);
				end else begin
					aim_engine(mv, 1, n);
					aim_engine(mv + rt, 2, n);
				end
			end
		endcase
		for (int i = 0; i < n; i++)
			if (rev_age[i] != AGE_TOP)
				rev_age[i]++;
		rr_ptr++;
		if (rr_ptr >= n)
			rr_ptr = 0;
		p = rr_ptr;
		if (rev_age[p] >= reg_lockout && aim_rev[p] != sent_rev[p]) begin
			rev_age[p]  = '0;
			sent_rev[p] = aim_rev[p];
			c.kind   = CMD_DIR;
			c.engine = IDX_W'(p);
			c.value  = MAG_W'(sent_rev[p]);
			return 1'b1;
		end
		if (aim_mag[p] != sent_mag[p]) begin
			sent_mag[p] = aim_mag[p];
			c.kind   = CMD_SPEED;
			c.engine = IDX_W'(p);
			c.value  = sent_mag[p];
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			CFG_ENGINE_COUNT: reg_engines = d[ECNT_W-1:0];
			CFG_LOCKOUT:      reg_lockout = d[LOCK_W-1:0];
			CFG_MANUAL_VERT:  reg_manual  = d[0];
			default: ;
		endcase
	endfunction

	task automatic check_cmd(engine_cmd_t got);
		engine_cmd_t want;
		cmds_seen++;
		if (got.kind == CMD_DIR)
			dir_cmds++;
		if (cmd_due.size() == 0) begin
			report_mismatch($sformatf("command kind %0d engine %0d value %0d with none due",
				got.kind, got.engine, got.value));
			return;
		end
		want = cmd_due.pop_front();
		if (got.kind !== want.kind)
			report_mismatch($sformatf("cmd_kind %0d, want %0d", got.kind, want.kind));
		if (got.engine !== want.engine)
			report_mismatch($sformatf("engine_index %0d, want %0d", got.engine, want.engine));
		if (got.value !== want.value)
			report_mismatch($sformatf("cmd_value %0d, want %0d (engine %0d)",
				got.value, want.value, want.engine));
	endtask

	// Drive ticks from the backlog; hold each one until its transfer
	always @(posedge clk) begin
		if (!tick_ch.valid || tick_ch.ready) begin
			if (tick_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_tick = tick_backlog.pop_front();
				tick_ch.valid        <= 1'b1;
				tick_ch.vert_manual  <= next_tick.vert_manual;
				tick_ch.vert_auto    <= next_tick.vert_auto;
				tick_ch.move_speed   <= next_tick.move_speed;
				tick_ch.rotate_speed <= next_tick.rotate_speed;
				tick_ch.mode         <= next_tick.mode;
			end else begin
				tick_ch.valid <= 1'b0;
			end
		end
	end

	// Count down a long receiver hold-off
	always @(posedge clk) begin
		if (hold_go)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// Stall the command side at random and during a hold-off
	always @(posedge clk) begin
		cmd_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
	end

	// Watch all three channels: check commands before queueing the new prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				apply_reg(cfg_ch.index, cfg_ch.data);
			if (cmd_ch.valid && cmd_ch.ready) begin
				seen_cmd.kind   = cmd_ch.cmd_kind;
				seen_cmd.engine = cmd_ch.engine_index;
				seen_cmd.value  = cmd_ch.cmd_value;
				check_cmd(seen_cmd);
			end
			if (tick_ch.valid && tick_ch.ready) begin
				seen_tick.vert_manual  = tick_ch.vert_manual;
				seen_tick.vert_auto    = tick_ch.vert_auto;
				seen_tick.move_speed   = tick_ch.move_speed;
				seen_tick.rotate_speed = tick_ch.rotate_speed;
				seen_tick.mode         = mode_t'(tick_ch.mode);
				if (mix_tick(seen_tick, due_cmd))
					cmd_due.push_back(due_cmd);
				ticks_taken++;
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= CFG_DATA_W'(value);
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// Wait for every tick to transfer and every command to arrive, then let the pipe empty
	task automatic wait_quiet();
		while (ticks_taken != ticks_queued)
			@(posedge clk);
		while (cmd_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_tick(int vm, int va, int mv, int rt, mode_t m);
		tick_t t;
		t.vert_manual  = CMD_W'(vm);
		t.vert_auto    = CMD_W'(va);
		t.move_speed   = CMD_W'(mv);
		t.rotate_speed = CMD_W'(rt);
		t.mode         = m;
		tick_backlog.push_back(t);
		ticks_queued++;
	endtask

	// Favour the range limits, otherwise any 9-bit value
	function automatic int random_cmd();
		case ($urandom_range(15))
			0: return -256;
			1: return -MIX_LIMIT;
			2: return MIX_LIMIT;
			3: return 0;
			4: return 1;
			5: return -1;
			default: return int'($urandom_range(511)) - 256;
		endcase
	endfunction

	task automatic run_phase(int engines, int lockout, int manual, int items,
		int s_pct, int r_pct, bit squeeze);
		int k;
		int run;
		int vm;
		int va;
		int mv;
		int rt;
		mode_t m;
		write_reg(CFG_ENGINE_COUNT, engines);
		write_reg(CFG_LOCKOUT, lockout);
		write_reg(CFG_MANUAL_VERT, manual);
		settings_run++;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		if (squeeze) begin
			@(posedge clk);
			hold_go <= 1'b1;
			@(posedge clk);
			hold_go <= 1'b0;
		end
		k = 0;
		while (k < items) begin
			vm = random_cmd();
			va = random_cmd();
			mv = random_cmd();
			rt = random_cmd();
			m  = mode_t'($urandom_range(3));
			// hold the commands steady now and then so lockouts run out and targets settle
			run = ($urandom_range(7) == 0) ? $urandom_range(24, 4) : 1;
			repeat (run) begin
				queue_tick(vm, va, mv, rt, m);
				k++;
			end
		end
		wait_quiet();
	endtask

	initial begin
		tick_ch.valid        = 1'b0;
		tick_ch.vert_manual  = '0;
		tick_ch.vert_auto    = '0;
		tick_ch.move_speed   = '0;
		tick_ch.rotate_speed = '0;
		tick_ch.mode         = MODE_STOP;
		cmd_ch.ready         = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.index         = CFG_ENGINE_COUNT;
		cfg_ch.data          = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks under the reset settings (automatic vertical source)
		send_idle_pct = 36;
		recv_idle_pct = 78;
		queue_tick(0, 0, 0, 0, MODE_STOP);
		queue_tick(-MIX_LIMIT, MIX_LIMIT, MIX_LIMIT, 0, MODE_MOVE);
		queue_tick(MIX_LIMIT, -MIX_LIMIT, -MIX_LIMIT, 0, MODE_MOVE);
		queue_tick(-256, -256, -256, -256, MODE_MOVE);
		queue_tick(0, 100, 100, 200, MODE_PITCH);
		queue_tick(0, -200, -200, -100, MODE_PITCH);
		queue_tick(0, 0, 0, MIX_LIMIT, MODE_YAW);
		queue_tick(0, 0, 0, -MIX_LIMIT, MODE_YAW);
		queue_tick(0, 0, 0, -256, MODE_YAW);
		queue_tick(0, 0, MIX_LIMIT, -MIX_LIMIT, MODE_MOVE);
		queue_tick(0, 0, -MIX_LIMIT, MIX_LIMIT, MODE_MOVE);
		queue_tick(MIX_LIMIT, MIX_LIMIT, MIX_LIMIT, MIX_LIMIT, MODE_STOP);
		// keep asking for reverse until the lockouts run out
		repeat (12) queue_tick(-256, -50, -50, 0, MODE_MOVE);
		wait_quiet();

		// Random phases across register settings, idling pattern as planned
		run_phase(8, 1, 1, 70, 36, 78, 1'b0);
		run_phase(3, 20, 0, 70, 36, 78, 1'b0);
		run_phase(0, 0, 1, 50, 78, 36, 1'b0);
		run_phase(15, 65535, 0, 50, 78, 36, 1'b0);
		run_phase(2, 5, 1, 60, 0, 0, 1'b1);
		run_phase(1, 3, 0, 40, 0, 0, 1'b0);
		run_phase(5, 10, 1, 60, 0, 0, 1'b0);

		$display("run covered %0d ticks over %0d register settings, engine counts 0 to 15,",
			ticks_taken, settings_run);
		$display("lockouts 0 to 65535; %0d commands checked, %0d of them direction changes",
			cmds_seen, dir_cmds);
		if (err_count == 0)
			$display("thruster_mix_reverse_lockout_test: done, clean");
		else
			$display("thruster_mix_reverse_lockout_test: done, errors");
		$finish;
	end

	// Give up if the run hangs
	initial begin
		#400000;
		$display("thruster_mix_reverse_lockout_test: done, errors");
		$finish;
	end

endmodule

### sim.f
+incdir+sv
sv/tmrl_pkg.sv
sv/tmrl_if.sv
sv/tmrl_mix.sv
sv/thruster_mix_reverse_lockout.sv
sv/tmrl_checker.sv
dv/thruster_mix_reverse_lockout_test.sv
